FILE: rtl/vmt_pkg.sv
// ---------------------------------------------------------------------------
// Vector move-towards package
// Shared types and constants for the controller and the datapath.
// ---------------------------------------------------------------------------
package vmt_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_CHASE = 2'd1;
  localparam logic [1:0] CMD_CLAMP = 2'd2;

  localparam logic [18:0] FRAME_TIME_RESET = 19'd65536;

  // Number of root bits and quotient bits produced one per cycle.
  localparam int ROOT_STEPS = 33;
  localparam int DIV_STEPS  = 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CHECK,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic       root_en;
    logic       snap;
    logic       div_init;
    logic       div_en;
    logic       scale_en;
    logic [1:0] idx;
    logic       out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       snap_ok;
    logic       need_div;
  } stat_t;

  // Saturate a 34-bit signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/vmt_ctrl.sv
// ---------------------------------------------------------------------------
// Vector move-towards controller
// Sequences squares, square root, division and scaling for one item.
// ---------------------------------------------------------------------------
module vmt_ctrl import vmt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  logic [1:0] command,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       out_valid_next;

  // State, counter and result flag registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    ctrl           = '0;
    ctrl.idx       = cnt[1:0];
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          cnt_next  = '0;
          if (command == CMD_CHASE || command == CMD_CLAMP) begin
            state_next = ST_SQUARE;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SQUARE: begin
        ctrl.sq_en = 1'b1;
        if (cnt == 6'd2) begin
          cnt_next   = '0;
          state_next = ST_ROOT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_ROOT: begin
        ctrl.root_en = 1'b1;
        if (cnt == 6'(ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_CHECK;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_CHECK: begin
        if (stat.snap_ok) begin
          ctrl.snap  = 1'b1;
          state_next = ST_OUT;
        end else if (stat.need_div) begin
          ctrl.div_init = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        ctrl.div_en = 1'b1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_SCALE;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_SCALE: begin
        ctrl.scale_en = 1'b1;
        if (cnt == 6'd2) begin
          cnt_next   = '0;
          state_next = ST_OUT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          ctrl.out_load  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/vmt_datapath.sv
// ---------------------------------------------------------------------------
// Vector move-towards datapath
// Position, operand vector, sum of squares, root, divider and scaler.
// ---------------------------------------------------------------------------
module vmt_datapath import vmt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         frame_time_we,
  input  logic [18:0]  frame_time_data,
  input  logic [1:0]   command,
  input  logic [31:0]  target_x,
  input  logic [31:0]  target_y,
  input  logic [31:0]  target_z,
  input  logic [30:0]  step_rate,
  input  logic [30:0]  max_length,
  input  ctrl_t        ctrl,
  output stat_t        stat,
  output logic [31:0]  position_x,
  output logic [31:0]  position_y,
  output logic [31:0]  position_z,
  output logic         reached
);

  logic [18:0] frame_time;
  logic [31:0] pos [3];
  logic [31:0] tgt [3];
  logic [31:0] vmag [3];
  logic        vneg [3];
  logic [1:0]  cmd;
  logic [33:0] step;
  logic [30:0] max_len;
  logic [65:0] sum;
  logic [65:0] rad;
  logic [35:0] rem;
  logic [32:0] root;
  logic [34:0] drem;
  logic [29:0] ratio;
  logic        reach;

  logic [31:0] in_t [3];
  logic [32:0] diff [3];
  logic [49:0] step_prod;
  logic [63:0] sq;
  logic [35:0] rem_s, trial;
  logic [34:0] drem_s;
  logic [33:0] divisor, dividend;
  logic [61:0] sprod;
  logic [31:0] smag;
  logic signed [33:0] snew;

  assign in_t[0] = target_x;
  assign in_t[1] = target_y;
  assign in_t[2] = target_z;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= FRAME_TIME_RESET;
    end else if (frame_time_we) begin
      frame_time <= frame_time_data;
    end
  end

  // Operand arithmetic for the capture cycle and the iterative units.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {in_t[i][31], in_t[i]} - {pos[i][31], pos[i]};
    end
    step_prod = frame_time * step_rate;
    sq        = vmag[ctrl.idx] * vmag[ctrl.idx];
    rem_s     = {rem[33:0], rad[65:64]};
    trial     = {1'b0, root, 2'b01};
    divisor   = {1'b0, root};
    dividend  = (cmd == CMD_CHASE) ? step : {3'd0, max_len};
    drem_s    = {drem[33:0], 1'b0};
    sprod     = vmag[ctrl.idx] * ratio;
    smag      = sprod[61:30];
    if (cmd == CMD_CHASE) begin
      snew = {{2{pos[ctrl.idx][31]}}, pos[ctrl.idx]}
           + (vneg[ctrl.idx] ? -$signed({2'b00, smag}) : $signed({2'b00, smag}));
    end else begin
      snew = vneg[ctrl.idx] ? -$signed({2'b00, smag}) : $signed({2'b00, smag});
    end
  end

  // Decision after the root is complete.
  assign stat.cmd      = cmd;
  assign stat.snap_ok  = (cmd == CMD_CHASE) && ({1'b0, root} <= step);
  assign stat.need_div = ((cmd == CMD_CHASE) && ({1'b0, root} > step))
                         || ((cmd == CMD_CLAMP) && ({1'b0, root} > {3'd0, max_len})
                             && (root != '0));

  // Position, operands and iteration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
      end
    end else begin
      if (ctrl.load) begin
        cmd     <= command;
        step    <= step_prod[49:16];
        max_len <= max_length;
        sum     <= '0;
        rem     <= '0;
        root    <= '0;
        reach   <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          tgt[i] <= in_t[i];
          if (command == CMD_CHASE) begin
            vneg[i] <= diff[i][32];
            vmag[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
          end else begin
            vneg[i] <= pos[i][31];
            vmag[i] <= pos[i][31] ? -pos[i] : pos[i];
          end
          if (command == CMD_LOAD) begin
            pos[i] <= in_t[i];
          end
        end
      end
      if (ctrl.sq_en) begin
        sum <= sum + {2'b00, sq};
        if (ctrl.idx == 2'd2) begin
          rad <= sum + {2'b00, sq};
        end
      end
      // One root bit per cycle.
      if (ctrl.root_en) begin
        rad <= {rad[63:0], 2'b00};
        if (rem_s >= trial) begin
          rem  <= rem_s - trial;
          root <= {root[31:0], 1'b1};
        end else begin
          rem  <= rem_s;
          root <= {root[31:0], 1'b0};
        end
      end
      if (ctrl.snap) begin
        reach <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          pos[i] <= tgt[i];
        end
      end
      // One quotient bit per cycle; the dividend is below the divisor.
      if (ctrl.div_init) begin
        drem  <= {1'b0, dividend};
        ratio <= '0;
      end
      if (ctrl.div_en) begin
        if (drem_s >= {1'b0, divisor}) begin
          drem  <= drem_s - {1'b0, divisor};
          ratio <= {ratio[28:0], 1'b1};
        end else begin
          drem  <= drem_s;
          ratio <= {ratio[28:0], 1'b0};
        end
      end
      if (ctrl.scale_en) begin
        pos[ctrl.idx] <= sat32(snew);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      position_x <= pos[0];
      position_y <= pos[1];
      position_z <= pos[2];
      reached    <= reach;
    end
  end

endmodule

FILE: rtl/vector_move_towards_clamp_core.sv
// Load and unused commands store the result directly; chase and clamp first
// run the bit-per-cycle square root, and a chase or clamp with rescale then
// also runs the restoring divider and the scaler.
// One item is in work at a time; the next is taken once the result is stored.
// Synchronous reset clears the position to zero and frame_time to 1.0.
// ---------------------------------------------------------------------------
// Vector move-towards core
// Top level: controller and datapath for move-towards and length clamp.
// ---------------------------------------------------------------------------
module vector_move_towards_clamp_core import vmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_time_we,
  input  logic [18:0] frame_time_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [30:0] step_rate,
  input  logic [30:0] max_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] position_x,
  output logic [31:0] position_y,
  output logic [31:0] position_z,
  output logic        reached
);

  ctrl_t ctrl;
  stat_t stat;

  vmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .command   (command),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  vmt_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .frame_time_we   (frame_time_we),
    .frame_time_data (frame_time_data),
    .command         (command),
    .target_x        (target_x),
    .target_y        (target_y),
    .target_z        (target_z),
    .step_rate       (step_rate),
    .max_length      (max_length),
    .ctrl            (ctrl),
    .stat            (stat),
    .position_x      (position_x),
    .position_y      (position_y),
    .position_z      (position_z),
    .reached         (reached)
  );

`ifndef SYNTH
  // An accepted item keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open straight after accept");

  // Scaling never overlaps an open input.
  a_scale_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.scale_en |-> !in_ready)
    else $error("scaling while input open");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("not idle after reset");
`endif

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Vector move-towards core testbench
// Drives load, chase, clamp and unused commands through the valid/ready
// channels and checks each returned vector against a directed expectation
// or a fixed-point predictor of the position state. Frame time is changed
// between phases, and both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
  import vmt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] tx, ty, tz;
    logic [30:0] rate, limit;
    bit          typed;
    logic [31:0] ex, ey, ez;
    logic        er;
  } vec_item_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic        hit;
  } vec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frame_time_we = 1'b0;
  logic [18:0] frame_time_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_LOAD;
  logic [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic [30:0] step_rate = '0, max_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] position_x, position_y, position_z;
  logic        reached;

  // Flags travelling with the item on the input channel.
  bit          cur_typed = 0;
  vec_result_t cur_expect;

  // Predictor state.
  logic signed [31:0] model_pos [3];
  logic [18:0]        model_frame_time;
  vec_result_t        pending_vectors [$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  snaps_seen = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_request = 0;
  int  idle_cycles = 0;
  bit  run_done = 0;

  vector_move_towards_clamp_core DUT (
    .clk(clk), .rst(rst),
    .frame_time_we(frame_time_we), .frame_time_data(frame_time_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .target_x(target_x), .target_y(target_y),
    .target_z(target_z), .step_rate(step_rate), .max_length(max_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .position_x(position_x), .position_y(position_y),
    .position_z(position_z), .reached(reached)
  );

  always #5 clk = ~clk;

  // Floor square root of a sum of three squares, bit pair by bit pair.
  function automatic logic [33:0] vector_length(input logic signed [33:0] d [3]);
    logic [65:0] sum;
    logic [33:0] mag;
    logic [69:0] rem, trial;
    logic [35:0] root;
    int k;
    sum = '0;
    for (k = 0; k < 3; k++) begin
      mag = d[k] < 0 ? -d[k] : d[k];
      sum = sum + 66'(mag) * 66'(mag);
    end
    rem = '0;
    root = '0;
    for (k = 32; k >= 0; k--) begin
      rem = (rem << 2) | 70'((sum >> (2 * k)) & 66'd3);
      trial = (70'(root) << 2) | 70'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 36'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[33:0];
  endfunction

  // Scale by ratio/2^30 with the magnitude truncated toward zero.
  function automatic logic signed [33:0] scaled_part(input logic signed [33:0] v,
                                                     input logic [29:0] ratio);
    logic [33:0] mag;
    logic [63:0] prod;
    mag = v < 0 ? -v : v;
    prod = (64'(mag) * 64'(ratio)) >> 30;
    return v < 0 ? -$signed(34'(prod)) : $signed(34'(prod));
  endfunction

  function automatic logic [31:0] clip32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Advance the predicted position by one command and return the vector.
  function automatic vec_result_t advance_position(input vec_item_t it);
    vec_result_t r;
    logic signed [33:0] tgt [3];
    logic signed [33:0] diff [3];
    logic signed [33:0] cur [3];
    logic [63:0] step;
    logic [33:0] span;
    logic [95:0] num;
    logic [29:0] ratio;
    int i;
    tgt[0] = 34'($signed(it.tx));
    tgt[1] = 34'($signed(it.ty));
    tgt[2] = 34'($signed(it.tz));
    for (i = 0; i < 3; i++) cur[i] = 34'(model_pos[i]);
    r.hit = 1'b0;
    case (it.cmd)
      CMD_LOAD: begin
        for (i = 0; i < 3; i++) model_pos[i] = tgt[i][31:0];
      end
      CMD_CHASE: begin
        step = (64'(model_frame_time) * 64'(it.rate)) >> 16;
        for (i = 0; i < 3; i++) diff[i] = tgt[i] - cur[i];
        span = vector_length(diff);
        if (64'(span) <= step) begin
          for (i = 0; i < 3; i++) model_pos[i] = tgt[i][31:0];
          r.hit = 1'b1;
        end else begin
          num = 96'(step) << 30;
          ratio = 30'(num / 96'(span));
          for (i = 0; i < 3; i++)
            model_pos[i] = clip32(cur[i] + scaled_part(diff[i], ratio));
        end
      end
      CMD_CLAMP: begin
        span = vector_length(cur);
        if (span > 34'(it.limit) && span > 0) begin
          num = 96'(it.limit) << 30;
          ratio = 30'(num / 96'(span));
          for (i = 0; i < 3; i++) model_pos[i] = clip32(scaled_part(cur[i], ratio));
        end
      end
      default: ;
    endcase
    r.px = model_pos[0];
    r.py = model_pos[1];
    r.pz = model_pos[2];
    return r;
  endfunction

  // Both channels are sampled at the falling edge, where every handshake
  // signal is settled before the rising edge that completes it.
  always @(negedge clk) begin
    vec_item_t   it;
    vec_result_t pred, want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        it.cmd = command;
        it.tx = target_x; it.ty = target_y; it.tz = target_z;
        it.rate = step_rate; it.limit = max_length;
        pred = advance_position(it);
        pending_vectors.push_back(cur_typed ? cur_expect : pred);
        items_sent++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (reached) snaps_seen++;
        if (pending_vectors.size() == 0) begin
          $error("result with no item outstanding: x=%h y=%h z=%h reached=%b",
                 position_x, position_y, position_z, reached);
          errors++;
        end else begin
          want = pending_vectors.pop_front();
          if (position_x !== want.px) begin
            $error("position_x expected %h actual %h", want.px, position_x);
            errors++;
          end
          if (position_y !== want.py) begin
            $error("position_y expected %h actual %h", want.py, position_y);
            errors++;
          end
          if (position_z !== want.pz) begin
            $error("position_z expected %h actual %h", want.pz, position_z);
            errors++;
          end
          if (reached !== want.hit) begin
            $error("reached expected %b actual %b", want.hit, reached);
            errors++;
          end
        end
      end
      // Watchdog on cycles with no movement on either channel.
      if ((in_valid && in_ready) || (out_valid && out_ready) || run_done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 pending_vectors.size());
        $display("vector_move_towards_clamp_core verification failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      out_ready <= 1'b0;
      hold_request <= hold_request - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input vec_item_t it);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= it.cmd;
    target_x <= it.tx; target_y <= it.ty; target_z <= it.tz;
    step_rate <= it.rate; max_length <= it.limit;
    cur_typed <= it.typed;
    cur_expect <= '{it.ex, it.ey, it.ez, it.er};
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_frame_time(input logic [18:0] value);
    frame_time_we <= 1'b1;
    frame_time_data <= value;
    @(posedge clk);
    frame_time_we <= 1'b0;
    model_frame_time = value;
  endtask

  // Drain all outstanding results and let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_vectors.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_component;
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      2: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic logic [30:0] rand_magnitude;
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(1 << 22));
      2: return 31'($urandom_range(1 << 16));
      default: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
    endcase
  endfunction

  function automatic vec_item_t rand_item;
    vec_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) it.cmd = CMD_LOAD;
    else if (pick < 60) it.cmd = CMD_CHASE;
    else if (pick < 90) it.cmd = CMD_CLAMP;
    else it.cmd = CMD_UNUSED;
    it.tx = rand_component();
    it.ty = rand_component();
    it.tz = rand_component();
    it.rate = rand_magnitude();
    it.limit = rand_magnitude();
    it.typed = 0;
    it.ex = '0; it.ey = '0; it.ez = '0; it.er = 1'b0;
    return it;
  endfunction

  vec_item_t   directed [$];
  logic [18:0] phase_frame_time [6];

  initial begin
    vec_item_t it;
    int p, n, i;

    // Directed rows: command, target, rate, limit, typed flag, expectation.
    directed = '{
      '{CMD_LOAD,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'd0, 31'd0,
        1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0},
      '{CMD_UNUSED, 32'h1234_5678, 32'hFFFF_FFFF, 32'h1, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
        1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0},
      // Zero distance snaps even with no speed.
      '{CMD_CHASE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'd0, 31'd0,
        1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1},
      '{CMD_CLAMP, 32'h0, 32'h0, 32'h0, 31'd0, 31'h7FFF_FFFF,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD,  32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
        1, 32'h0, 32'h0, 32'h0, 1'b0},
      // Zero length is left alone even with a zero limit.
      '{CMD_CLAMP, 32'hFFFF_FFFF, 32'h1, 32'h0, 31'd0, 31'd0,
        1, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD,  32'h0003_0000, 32'h0004_0000, 32'h0, 31'd0, 31'd0,
        1, 32'h0003_0000, 32'h0004_0000, 32'h0, 1'b0},
      // Length exactly at the limit stays put.
      '{CMD_CLAMP, 32'h0, 32'h0, 32'h0, 31'd0, 31'h0005_0000,
        1, 32'h0003_0000, 32'h0004_0000, 32'h0, 1'b0},
      '{CMD_CLAMP, 32'h0, 32'h0, 32'h0, 31'd0, 31'h0002_8000,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_CLAMP, 32'h0, 32'h0, 32'h0, 31'd0, 31'd0,
        1, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_CHASE, 32'h0001_0000, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'd0,
        1, 32'h0001_0000, 32'h0, 32'h0, 1'b1},
      // No speed leaves the vector where it is.
      '{CMD_CHASE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 31'd0,
        1, 32'h0001_0000, 32'h0, 32'h0, 1'b0},
      '{CMD_CHASE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0010_0000, 31'd0,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_CHASE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h5555_5555, 31'd0,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_CLAMP, 32'h0, 32'h0, 32'h0, 31'd0, 31'h7FFF_FFFF,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_CLAMP, 32'h0, 32'h0, 32'h0, 31'd0, 31'h2AAA_AAAA,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_CHASE, 32'h0, 32'h0, 32'h0, 31'h2AAA_AAAA, 31'd0,
        0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd0,
        0, 32'h0, 32'h0, 32'h0, 1'b0}
    };
    phase_frame_time = '{19'd0, 19'd262144, 19'd1, 19'd65536, 19'd0, 19'd0};
    phase_frame_time[4] = 19'($urandom_range(262144));
    phase_frame_time[5] = 19'($urandom_range(262144));

    // Reset, then the predictor starts from the reset state.
    for (i = 0; i < 3; i++) model_pos[i] = '0;
    model_frame_time = FRAME_TIME_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_item(directed[k]);
    drain();

    // Random phases, each with its frame time and an idling pattern that repeats every four phases.
    for (p = 0; p < 6; p++) begin
      write_frame_time(phase_frame_time[p]);
      send_idle_pct  = (p % 4 == 1 || p % 4 == 3) ? (p % 4 == 3 ? 37 : 62) : 0;
      recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? (p % 4 == 3 ? 37 : 62) : 0;
      if (p == 4) hold_request <= HOLD_CYCLES;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        it = rand_item();
        send_item(it);
      end
      drain();
    end
    cur_typed <= 0;

    run_done = 1;
    $display("Covered %0d items and %0d results (%0d snapped onto target)",
             items_sent, results_seen, snaps_seen);
    $display("over six frame-time settings from zero to 4.0, with idling and a long stall.");
    if (errors == 0) begin
      $display("vector_move_towards_clamp_core verification clean");
    end else begin
      $display("vector_move_towards_clamp_core verification failed");
    end
    $finish;
  end

endmodule
